>>> rtl/best_segment_scanner_unit_defines.svh
// Assertion macros used by the checker file bss_checker.sv.
`ifndef BEST_SEGMENT_SCANNER_UNIT_DEFINES_SVH
`define BEST_SEGMENT_SCANNER_UNIT_DEFINES_SVH

// Check a property while reset is released.
`define BSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

// Check a property at every edge, reset included.
`define BSS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

>>> rtl/bss_pkg.sv
package bss_pkg;

    localparam int SCORE_W = 24;
    localparam int ACC_W   = 40;
    localparam int POS_W   = 16;
    localparam int RUNGS_W = 17;
    localparam int CFG_IDX_W = 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUNGS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SCORE_W-1:0] start_score;
        logic signed [SCORE_W-1:0] extend_score;
        logic signed [SCORE_W-1:0] end_score;
        logic                      final_rung;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]        seg_first;
        logic [POS_W-1:0]        seg_end;
        logic signed [ACC_W-1:0] seg_score;
        logic                    last_of_run;
    } t_result;

    // Results of one rung, older segment in slot 0.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    item1;
        t_result    item0;
    } t_push;

    function automatic logic signed [ACC_W-1:0] sext_score(
        input logic signed [SCORE_W-1:0] v
    );
        sext_score = {{(ACC_W-SCORE_W){v[SCORE_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   a,
        input logic signed [SCORE_W-1:0] b
    );
        logic [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {{(ACC_W+1-SCORE_W){b[SCORE_W-1]}}, b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

>>> rtl/bss_channels.sv
interface bss_item_if;
    import bss_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] start_score;
    logic signed [SCORE_W-1:0] extend_score;
    logic signed [SCORE_W-1:0] end_score;
    logic                      final_rung;

    modport source (output valid, start_score, extend_score, end_score, final_rung,
                    input ready);
    modport sink   (input valid, start_score, extend_score, end_score, final_rung,
                    output ready);
endinterface

interface bss_result_if;
    import bss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        seg_first;
    logic [POS_W-1:0]        seg_end;
    logic signed [ACC_W-1:0] seg_score;
    logic                    last_of_run;

    modport source (output valid, seg_first, seg_end, seg_score, last_of_run,
                    input ready);
    modport sink   (input valid, seg_first, seg_end, seg_score, last_of_run,
                    output ready);
endinterface

interface bss_cfg_if;
    import bss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ACC_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/best_segment_scanner_unit.sv
// Channel   Dir  Transfer                 Payload
// i_item    in   valid & ready            start/extend/end score, final_rung
// o_res     out  valid & ready            seg_first, seg_end, seg_score, last_of_run
// i_cfg     in   valid & ready (always)   index, data
//
// One rung per cycle sustained while the result queue has room: the
// running-score / best-end recurrence is combinational in bss_core.
// A rung waits in the input register until the queue can take two results;
// its results are then written into the result queue, from which they are
// offered on o_res.
// Reset (synchronous, active low) clears the scan state and the queue and
// sets minimum rungs to 1 and minimum score to 0.
// The input stalls while the four-entry result queue has fewer than two
// free entries; output stalls never block configuration writes.
module best_segment_scanner_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bss_item_if.sink            i_item,
    bss_result_if.source        o_res,
    bss_cfg_if.sink             i_cfg
);
    import bss_pkg::*;

    logic [RUNGS_W-1:0]      r_min_rungs;
    logic signed [ACC_W-1:0] r_min_score;

    logic    r_in_vld;
    t_item   r_in;
    logic    room;
    logic    fire;
    t_push   push;
    t_result res;

    // Configuration: always ready, write at transfer.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rungs <= RUNGS_W'(1);
            r_min_score <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MIN_RUNGS: r_min_rungs <= i_cfg.data[RUNGS_W-1:0];
                CFG_MIN_SCORE: r_min_score <= i_cfg.data;
            endcase
        end
    end

    // Input register: advance when the queue can take two results.
    assign fire         = r_in_vld && room;
    assign i_item.ready = !r_in_vld || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.start_score  <= i_item.start_score;
            r_in.extend_score <= i_item.extend_score;
            r_in.end_score    <= i_item.end_score;
            r_in.final_rung   <= i_item.final_rung;
        end
    end

    bss_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_min_rungs (r_min_rungs),
        .i_min_score (r_min_score),
        .o_push      (push)
    );

    // Result queue: both results of a rung enter together, older first.
    bss_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_room  (room),
        .o_valid (o_res.valid),
        .o_res   (res)
    );

    assign o_res.seg_first   = res.seg_first;
    assign o_res.seg_end     = res.seg_end;
    assign o_res.seg_score   = res.seg_score;
    assign o_res.last_of_run = res.last_of_run;

endmodule

>>> rtl/bss_core.sv
module bss_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  bss_pkg::t_item                  i_item,
    input  logic [bss_pkg::RUNGS_W-1:0]     i_min_rungs,
    input  logic signed [bss_pkg::ACC_W-1:0] i_min_score,
    output bss_pkg::t_push                  o_push
);
    import bss_pkg::*;

    logic signed [ACC_W-1:0] r_rs, n_rs;
    logic [POS_W-1:0]        r_ss, n_ss;
    logic [POS_W-1:0]        r_rp, n_rp;
    logic signed [ACC_W-1:0] r_bt, n_bt;
    logic [POS_W-1:0]        r_be, n_be;
    logic                    r_bv, n_bv;

    logic signed [ACC_W-1:0] s_new, s_old, t_end;
    logic [RUNGS_W-1:0]      seg_len;
    logic                    close1, close2, rep1, rep2;
    t_result                 res1, res2;

    always_comb begin
        s_new  = sext_score(i_item.start_score);
        s_old  = sat_add(r_rs, i_item.extend_score);
        close1 = 1'b0;
        n_ss   = r_ss;
        n_bv   = r_bv;
        n_bt   = r_bt;
        n_be   = r_be;
        if (r_rp == '0) begin
            n_bv = 1'b0;
            n_rs = s_new;
            n_ss = '0;
        end else if (s_new > s_old) begin
            // fresh start beats extending: close the open segment
            close1 = 1'b1;
            n_rs   = s_new;
            n_ss   = r_rp;
            n_bv   = 1'b0;
        end else begin
            n_rs = s_old;
        end

        seg_len = {1'b0, r_rp - n_ss} + RUNGS_W'(1);
        t_end   = sat_add(n_rs, i_item.end_score);
        if (seg_len >= i_min_rungs && (!n_bv || t_end >= n_bt)) begin
            n_bt = t_end;
            n_be = r_rp;
            n_bv = 1'b1;
        end

        close2 = i_item.final_rung || (r_rp == '1);
        n_rp   = close2 ? '0 : r_rp + POS_W'(1);
    end

    always_comb begin
        rep1 = i_fire && close1 && r_bv && (r_bt >= i_min_score);
        rep2 = i_fire && close2 && n_bv && (n_bt >= i_min_score);

        res1.seg_first   = r_ss;
        res1.seg_end     = r_be;
        res1.seg_score   = r_bt;
        res1.last_of_run = !rep2;

        res2.seg_first   = n_ss;
        res2.seg_end     = n_be;
        res2.seg_score   = n_bt;
        res2.last_of_run = 1'b1;

        o_push.cnt   = {1'b0, rep1} + {1'b0, rep2};
        o_push.item0 = rep1 ? res1 : res2;
        o_push.item1 = res2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs <= '0;
            r_ss <= '0;
            r_rp <= '0;
            r_bt <= '0;
            r_be <= '0;
            r_bv <= 1'b0;
        end else if (i_fire) begin
            r_rs <= n_rs;
            r_ss <= n_ss;
            r_rp <= n_rp;
            r_bt <= n_bt;
            r_be <= n_be;
            r_bv <= close2 ? 1'b0 : n_bv;
        end
    end

endmodule

>>> rtl/bss_result_fifo.sv
module bss_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bss_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output bss_pkg::t_result o_res
);
    import bss_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_cnt <= (Q_AW+1)'(Q_DEPTH - 2));
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + Q_AW'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push.cnt);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + (Q_AW+1)'(i_push.cnt) - (Q_AW+1)'(pop);
        end
    end

endmodule

>>> rtl/bss_checker.sv
`include "best_segment_scanner_unit_defines.svh"

module bss_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [bss_pkg::POS_W-1:0] i_seg_first,
    input logic [bss_pkg::POS_W-1:0] i_seg_end,
    input logic                     i_last_of_run
);
    import bss_pkg::*;

    // hold a result until it is taken
    `BSS_ASSERT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // a segment never ends before it starts
    `BSS_ASSERT(a_seg_order, i_clk, i_rst_n, i_out_valid |-> i_seg_end >= i_seg_first)
    // the second result of a pair is queued with the first
    `BSS_ASSERT(a_pair_follows, i_clk, i_rst_n, i_out_valid && !i_last_of_run |=> i_out_valid)
    // nothing is offered right after reset
    `BSS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind best_segment_scanner_unit bss_checker u_bss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_seg_first   (o_res.seg_first),
    .i_seg_end     (o_res.seg_end),
    .i_last_of_run (o_res.last_of_run)
);

>>> tb/best_segment_scanner_unit_checker.sv
module best_segment_scanner_unit_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bss_item_if   item_mon,
    bss_result_if res_mon,
    bss_cfg_if    cfg_mon,
    output int    o_mismatches,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bss_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the configuration registers.
    logic [RUNGS_W-1:0]      min_span;
    logic signed [ACC_W-1:0] floor_score;

    // Shadow of the scan state.
    logic signed [ACC_W-1:0] run_sum;
    logic [POS_W-1:0]        seg_origin;
    logic [POS_W-1:0]        rung_idx;
    logic signed [ACC_W-1:0] best_sum;
    logic [POS_W-1:0]        best_rung;
    logic                    best_seen;

    t_result expected_segments[$];
    int      mismatch_count = 0;
    int      closed_now;

    function automatic logic signed [ACC_W-1:0] add_clamped(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [SCORE_W-1:0] step
    );
        logic signed [ACC_W:0] wide;
        wide = acc + step;
        if (wide > ACC_MAX) begin
            return ACC_MAX;
        end
        if (wide < ACC_MIN) begin
            return ACC_MIN;
        end
        return wide[ACC_W-1:0];
    endfunction

    // Close the open segment; queue it if it has an eligible end that scores enough.
    task automatic close_open_segment();
        t_result seg;
        if (best_seen && best_sum >= floor_score) begin
            seg.seg_first   = seg_origin;
            seg.seg_end     = best_rung;
            seg.seg_score   = best_sum;
            seg.last_of_run = 1'b0;
            expected_segments.push_back(seg);
            closed_now++;
        end
        best_seen = 1'b0;
    endtask

    task automatic predict_segments(input t_item rung);
        logic signed [ACC_W-1:0] fresh;
        logic signed [ACC_W-1:0] extended;
        logic signed [ACC_W-1:0] total;
        logic [RUNGS_W-1:0]      span;
        closed_now = 0;
        fresh = $signed(rung.start_score);
        if (rung_idx == '0) begin
            best_seen  = 1'b0;
            run_sum    = fresh;
            seg_origin = '0;
        end else begin
            extended = add_clamped(run_sum, rung.extend_score);
            // Strictly better start wins; ties extend.
            if (fresh > extended) begin
                close_open_segment();
                run_sum    = fresh;
                seg_origin = rung_idx;
            end else begin
                run_sum = extended;
            end
        end
        span = RUNGS_W'(rung_idx - seg_origin) + 1'b1;
        if (span >= min_span) begin
            total = add_clamped(run_sum, rung.end_score);
            if (!best_seen || total >= best_sum) begin
                best_sum  = total;
                best_rung = rung_idx;
                best_seen = 1'b1;
            end
        end
        // The last possible index ends the pairing even without the flag.
        if (rung.final_rung || rung_idx == {POS_W{1'b1}}) begin
            close_open_segment();
            rung_idx = '0;
        end else begin
            rung_idx = rung_idx + 1'b1;
        end
        if (closed_now > 0) begin
            expected_segments[expected_segments.size()-1].last_of_run = 1'b1;
        end
    endtask

    task automatic check_segment();
        t_result want;
        if (expected_segments.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected segment: first=%0d end=%0d score=%0d last=%0b",
                         res_mon.seg_first, res_mon.seg_end, res_mon.seg_score,
                         res_mon.last_of_run);
            end
        end else begin
            want = expected_segments.pop_front();
            if (want.seg_first !== res_mon.seg_first || want.seg_end !== res_mon.seg_end ||
                want.seg_score !== res_mon.seg_score ||
                want.last_of_run !== res_mon.last_of_run) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("segment mismatch: expected first=%0d end=%0d score=%0d last=%0b",
                             want.seg_first, want.seg_end, want.seg_score,
                             want.last_of_run);
                    $display("                  actual   first=%0d end=%0d score=%0d last=%0b",
                             res_mon.seg_first, res_mon.seg_end, res_mon.seg_score,
                             res_mon.last_of_run);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_span    = RUNGS_W'(1);
            floor_score = '0;
            run_sum     = '0;
            seg_origin  = '0;
            rung_idx    = '0;
            best_sum    = '0;
            best_rung   = '0;
            best_seen   = 1'b0;
            expected_segments.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                if (cfg_mon.index == CFG_MIN_RUNGS) begin
                    min_span = cfg_mon.data[RUNGS_W-1:0];
                end else if (cfg_mon.index == CFG_MIN_SCORE) begin
                    floor_score = cfg_mon.data;
                end
            end
            if (item_mon.valid && item_mon.ready) begin
                predict_segments('{start_score:  item_mon.start_score,
                                   extend_score: item_mon.extend_score,
                                   end_score:    item_mon.end_score,
                                   final_rung:   item_mon.final_rung});
            end
            if (res_mon.valid && res_mon.ready) begin
                check_segment();
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_segments.size();
    end

endmodule

>>> tb/best_segment_scanner_unit_tb.sv
module best_segment_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bss_pkg::*;

    // Cycles to let a rung that closes nothing drain out of the pipeline.
    localparam int SETTLE_CYCLES = 8;
    // Quiet cycles (no transfer on any channel) before the run is declared hung.
    localparam int QUIET_LIMIT   = 5000;
    localparam int BLOCK_ITEMS   = 100;

    localparam logic signed [SCORE_W-1:0] S_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] S_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int quiet_cycles = 0;
    int mismatches;
    int pending;

    bss_item_if   item_if();
    bss_result_if res_if();
    bss_cfg_if    cfg_if();

    best_segment_scanner_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    best_segment_scanner_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_mon     (item_if),
        .res_mon      (res_if),
        .cfg_mon      (cfg_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // Throttle the result side; zero percent holds ready high.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: any transfer on any channel resets the quiet count.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_item make_rung(
        input logic signed [SCORE_W-1:0] start_s,
        input logic signed [SCORE_W-1:0] extend_s,
        input logic signed [SCORE_W-1:0] end_s,
        input logic                      fin
    );
        t_item r;
        r.start_score  = start_s;
        r.extend_score = extend_s;
        r.end_score    = end_s;
        r.final_rung   = fin;
        return r;
    endfunction

    // Mix full-range scores (every bit toggles) with small ones so that
    // start-versus-extend decisions stay close and segments grow.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        logic signed [SCORE_W-1:0] s;
        int                        v;
        case ($urandom_range(5))
            0, 1: s = SCORE_W'($urandom);
            2, 3: begin
                v = int'($urandom_range(511)) - 256;
                s = SCORE_W'(v);
            end
            4: begin
                v = int'($urandom_range(40)) - 16;
                s = SCORE_W'(v);
            end
            default: begin
                case ($urandom_range(3))
                    0:       s = S_MAX;
                    1:       s = S_MIN;
                    2:       s = '0;
                    default: s = '1;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic logic [ACC_W-1:0] pick_min_rungs();
        logic [ACC_W-1:0] d;
        case ($urandom_range(9))
            0:       d = '0;
            1, 2:    d = ACC_W'(1);
            3, 4, 5: d = ACC_W'($urandom_range(2, 6));
            6:       d = ACC_W'($urandom_range(7, 40));
            7:       d = ACC_W'(65536);
            8:       d = ACC_W'($urandom_range(131071));
            default: d = ACC_W'($urandom_range(1, 3));
        endcase
        return d;
    endfunction

    function automatic logic [ACC_W-1:0] pick_min_score();
        logic [ACC_W-1:0] d;
        int               v;
        case ($urandom_range(9))
            0: d = ACC_MIN;
            1: d = ACC_MAX;
            2: d = ACC_W'({$urandom, $urandom});
            3: d = '0;
            default: begin
                v = int'($urandom_range(4000)) - 2000;
                d = ACC_W'(v);
            end
        endcase
        return d;
    endfunction

    // Present one rung and hold it until the block takes it.
    task automatic send_rung(input t_item rung);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.start_score  <= rung.start_score;
        item_if.extend_score <= rung.extend_score;
        item_if.end_score    <= rung.end_score;
        item_if.final_rung   <= rung.final_rung;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every predicted segment has come out,
    // then let the pipeline run dry.
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] data);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed();
        // Report everything while exercising field extremes.
        write_reg(CFG_MIN_RUNGS, ACC_W'(1));
        write_reg(CFG_MIN_SCORE, ACC_MIN);
        // Rung zero ignores its step score and always starts fresh.
        send_rung(make_rung(S_MAX, S_MIN, S_MIN, 1'b0));
        send_rung(make_rung(S_MIN, S_MAX, S_MAX, 1'b0));
        // A better start closes the open segment.
        send_rung(make_rung(S_MAX, S_MIN, '0, 1'b0));
        // Fresh start on the final rung: old segment, then the new one.
        send_rung(make_rung(S_MAX, S_MIN, S_MAX, 1'b1));
        // Single-rung pairings with zero and with minimum scores.
        send_rung(make_rung('0, '0, '0, 1'b1));
        send_rung(make_rung(S_MIN, S_MIN, S_MIN, 1'b1));

        // Ties extend, and an equal total moves the end to the later rung.
        write_reg(CFG_MIN_SCORE, '0);
        send_rung(make_rung(24'sd10, S_MIN, '0, 1'b0));
        send_rung(make_rung(24'sd10, '0, '0, 1'b1));

        // Segments shorter than the minimum are dropped.
        write_reg(CFG_MIN_RUNGS, ACC_W'(3));
        send_rung(make_rung('0, '0, '0, 1'b0));
        send_rung(make_rung(S_MAX, S_MIN, '0, 1'b1));

        // Zero minimum length acts as one.
        write_reg(CFG_MIN_RUNGS, '0);
        send_rung(make_rung(24'sd5, '0, 24'sd5, 1'b1));

        // A minimum beyond any pairing length silences everything.
        write_reg(CFG_MIN_RUNGS, ACC_W'(131071));
        write_reg(CFG_MIN_SCORE, ACC_MAX);
        send_rung(make_rung(S_MAX, S_MAX, S_MAX, 1'b0));
        send_rung(make_rung(S_MAX, S_MAX, S_MAX, 1'b0));
        send_rung(make_rung(S_MIN, S_MAX, S_MAX, 1'b1));
    endtask

    task automatic run_random_block();
        int   sent;
        int   span;
        logic fin;
        sent = 0;
        write_reg(CFG_MIN_RUNGS, pick_min_rungs());
        write_reg(CFG_MIN_SCORE, pick_min_score());
        while (sent < BLOCK_ITEMS) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < span; k++) begin
                // Occasionally break the pairing early.
                fin = (k == span - 1) || ($urandom_range(24) == 0);
                send_rung(make_rung(pick_score(), pick_score(), pick_score(), fin));
                sent++;
            end
            if ($urandom_range(14) == 0) begin
                settle();
            end
        end
    endtask

    initial begin
        item_if.valid        <= 1'b0;
        item_if.start_score  <= '0;
        item_if.extend_score <= '0;
        item_if.end_score    <= '0;
        item_if.final_rung   <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_MIN_RUNGS;
        cfg_if.data          <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily.
        src_idle_pct = 35;
        snk_idle_pct = 86;
        run_directed();
        repeat (4) run_random_block();

        // Swap the pressure.
        src_idle_pct = 86;
        snk_idle_pct = 35;
        repeat (4) run_random_block();

        // Full rate both ways.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (4) run_random_block();

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
